// ===== src/scd_pkg.sv =====
package scd_pkg;

  localparam int KEY_COUNT = 128;
  localparam int KEY_W = $clog2(KEY_COUNT);
  localparam int CHAR_W = 7;
  localparam int CFG_INDEX_W = 2;

  localparam logic [7:0] PREFIX_BYTE = 8'he0;
  localparam logic [7:0] PAUSE_BYTE = 8'he1;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_SHIFT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_SHIFT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPS_LOCK = 2'd2;

  localparam logic [KEY_W-1:0] LEFT_SHIFT_RESET = 7'd42;
  localparam logic [KEY_W-1:0] RIGHT_SHIFT_RESET = 7'd54;
  localparam logic [KEY_W-1:0] CAPS_LOCK_RESET = 7'd58;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'd90;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'd122;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;

  localparam logic [KEY_W-1:0] KEY_KEYPAD_ENTER = 7'd28;
  localparam logic [KEY_W-1:0] KEY_KEYPAD_SLASH = 7'd53;
  localparam logic [CHAR_W-1:0] CHAR_RETURN = 7'd13;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'd47;

  localparam logic [CHAR_W-1:0] TAB_PLAIN [KEY_COUNT] = '{
    7'd0, 7'd27, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
    7'd55, 7'd56, 7'd57, 7'd48, 7'd45, 7'd61, 7'd8, 7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91, 7'd93, 7'd13, 7'd0, 7'd97, 7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
    7'd39, 7'd96, 7'd0, 7'd92, 7'd122, 7'd120, 7'd99, 7'd118,
    7'd98, 7'd110, 7'd109, 7'd44, 7'd46, 7'd47, 7'd0, 7'd42,
    7'd0, 7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd55,
    7'd56, 7'd57, 7'd45, 7'd52, 7'd53, 7'd54, 7'd43, 7'd49,
    7'd50, 7'd51, 7'd48, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  localparam logic [CHAR_W-1:0] TAB_SHIFT [KEY_COUNT] = '{
    7'd0, 7'd27, 7'd33, 7'd64, 7'd35, 7'd36, 7'd37, 7'd94,
    7'd38, 7'd42, 7'd40, 7'd41, 7'd95, 7'd43, 7'd8, 7'd9,
    7'd81, 7'd87, 7'd69, 7'd82, 7'd84, 7'd89, 7'd85, 7'd73,
    7'd79, 7'd80, 7'd123, 7'd125, 7'd13, 7'd0, 7'd65, 7'd83,
    7'd68, 7'd70, 7'd71, 7'd72, 7'd74, 7'd75, 7'd76, 7'd58,
    7'd34, 7'd126, 7'd0, 7'd124, 7'd90, 7'd88, 7'd67, 7'd86,
    7'd66, 7'd78, 7'd77, 7'd60, 7'd62, 7'd63, 7'd0, 7'd42,
    7'd0, 7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd55,
    7'd56, 7'd57, 7'd45, 7'd52, 7'd53, 7'd54, 7'd43, 7'd49,
    7'd50, 7'd51, 7'd48, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    logic              is_make;
    logic              is_break;
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic [KEY_W-1:0]  previous_code;
    logic              caps_active;
    logic              shift_held;
    logic              pause_seen;
    logic              prefix_pending;
    logic              key_event;
  } scd_result_t;

  function automatic logic [CHAR_W-1:0] prefixed_char(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (key == KEY_KEYPAD_ENTER) begin
      ch = CHAR_RETURN;
    end else if (key == KEY_KEYPAD_SLASH) begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

// ===== src/scan_code_key_decoder.sv =====
// Decodes PC set-1 keyboard scan code bytes, one byte per transfer, into key events and
// ASCII characters, tracking a 128-key down map, the E0 prefix and the caps lock toggle.
// The block takes one byte every clock cycle for as long as results are taken; each accepted
// byte passes through the input register and then the result register, with the table lookup
// and state update between them, and waits there while a result is not taken. Configuration
// writes to the shift and caps lock key numbers are taken every cycle and belong only while no
// byte is in flight.
module scan_code_key_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scd_pkg::KEY_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      scan_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [scd_pkg::KEY_W-1:0]       key_code,
  output logic                            is_make,
  output logic                            is_break,
  output logic [scd_pkg::CHAR_W-1:0]      char_code,
  output logic                            char_valid,
  output logic [scd_pkg::KEY_W-1:0]       previous_code,
  output logic                            caps_active,
  output logic                            shift_held,
  output logic                            pause_seen,
  output logic                            prefix_pending,
  output logic                            key_event
);
  import scd_pkg::*;

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        advance;
  logic        step;
  scd_result_t core_result;
  scd_result_t result;

  assign advance = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;
  assign step = stage_valid && advance;
  assign cfg_ready = 1'b1;

  scd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .scan_byte (stage_byte),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= core_result;
    end
  end

  assign key_code = result.key_code;
  assign is_make = result.is_make;
  assign is_break = result.is_break;
  assign char_code = result.char_code;
  assign char_valid = result.char_valid;
  assign previous_code = result.previous_code;
  assign caps_active = result.caps_active;
  assign shift_held = result.shift_held;
  assign pause_seen = result.pause_seen;
  assign prefix_pending = result.prefix_pending;
  assign key_event = result.key_event;

endmodule

// ===== src/scd_xlate.sv =====
module scd_xlate (
  input  logic [scd_pkg::KEY_W-1:0]  key,
  input  logic                       prefixed,
  input  logic                       shifted,
  input  logic                       caps,
  output logic [scd_pkg::CHAR_W-1:0] char_code
);
  import scd_pkg::*;

  logic [CHAR_W-1:0] plain_ch;
  logic [CHAR_W-1:0] shift_ch;

  assign plain_ch = TAB_PLAIN[key];
  assign shift_ch = TAB_SHIFT[key];

  always_comb begin
    if (prefixed) begin
      char_code = prefixed_char(key);
    end else if (shifted) begin
      if (caps && shift_ch >= CHAR_UPPER_A && shift_ch <= CHAR_UPPER_Z) begin
        char_code = shift_ch + CASE_OFFSET;
      end else begin
        char_code = shift_ch;
      end
    end else begin
      if (caps && plain_ch >= CHAR_LOWER_A && plain_ch <= CHAR_LOWER_Z) begin
        char_code = plain_ch - CASE_OFFSET;
      end else begin
        char_code = plain_ch;
      end
    end
  end

endmodule

// ===== src/scd_core.sv =====
module scd_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [scd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scd_pkg::KEY_W-1:0]       cfg_data,
  input  logic                            step,
  input  logic [7:0]                      scan_byte,
  output scd_pkg::scd_result_t            result
);
  import scd_pkg::*;

  logic [KEY_W-1:0]     left_shift_code;
  logic [KEY_W-1:0]     right_shift_code;
  logic [KEY_W-1:0]     caps_lock_code;
  logic [KEY_COUNT-1:0] key_down_map;
  logic [KEY_COUNT-1:0] key_down_map_next;
  logic                 prefix_flag;
  logic                 prefix_flag_next;
  logic                 caps_state;
  logic                 caps_state_next;
  logic [KEY_W-1:0]     current_key;
  logic [KEY_W-1:0]     prior_key;
  logic [KEY_W-1:0]     prior_key_next;

  logic              is_prefix;
  logic              is_pause;
  logic              is_make;
  logic              is_break;
  logic [KEY_W-1:0]  key;
  logic              shift_now;
  logic [CHAR_W-1:0] xlate_ch;
  logic [CHAR_W-1:0] char_code;

  assign is_prefix = (scan_byte == PREFIX_BYTE);
  assign is_pause = (scan_byte == PAUSE_BYTE);
  assign key = scan_byte[KEY_W-1:0];
  assign is_break = !is_prefix && !is_pause && scan_byte[7];
  assign is_make = !is_prefix && !is_pause && !scan_byte[7];

  always_comb begin
    key_down_map_next = key_down_map;
    if (is_break) begin
      key_down_map_next[key] = 1'b0;
    end else if (is_make) begin
      key_down_map_next[key] = 1'b1;
    end
  end

  assign shift_now = key_down_map_next[left_shift_code] | key_down_map_next[right_shift_code];
  assign caps_state_next = caps_state ^ (is_make && !prefix_flag && key == caps_lock_code);
  assign prefix_flag_next = is_prefix ? 1'b1 : (is_pause ? prefix_flag : 1'b0);
  assign prior_key_next = is_make ? current_key : prior_key;

  scd_xlate u_xlate (
    .key       (key),
    .prefixed  (prefix_flag),
    .shifted   (shift_now),
    .caps      (caps_state_next),
    .char_code (xlate_ch)
  );

  assign char_code = is_make ? xlate_ch : '0;

  always_comb begin
    result.key_code = (is_make || is_break) ? key : '0;
    result.is_make = is_make;
    result.is_break = is_break;
    result.char_code = char_code;
    result.char_valid = is_make && (char_code != '0);
    result.previous_code = prior_key_next;
    result.caps_active = caps_state_next;
    result.shift_held = shift_now;
    result.pause_seen = is_pause;
    result.prefix_pending = prefix_flag_next;
    result.key_event = !prefix_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_shift_code <= LEFT_SHIFT_RESET;
      right_shift_code <= RIGHT_SHIFT_RESET;
      caps_lock_code <= CAPS_LOCK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEFT_SHIFT:  left_shift_code <= cfg_data;
        CFG_RIGHT_SHIFT: right_shift_code <= cfg_data;
        CFG_CAPS_LOCK:   caps_lock_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down_map <= '0;
      prefix_flag <= 1'b0;
      caps_state <= 1'b0;
      current_key <= '0;
      prior_key <= '0;
    end else if (step) begin
      key_down_map <= key_down_map_next;
      prefix_flag <= prefix_flag_next;
      caps_state <= caps_state_next;
      prior_key <= prior_key_next;
      if (is_make) begin
        current_key <= key;
      end
    end
  end

endmodule
